// ===== rtl/core/lpfd_pkg.sv =====
// Package with the shared constants, types and codes of the length-prefixed frame deframer.
package lpfd_pkg;

    localparam int FRAME_SLOTS = 4;
    localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int SLOT_OUT_W  = 2;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd85;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 1'b0,
        CFG_END_BYTE   = 1'b1
    } cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_SYNC    = 3'd0,
        PH_ID      = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4,
        PH_END     = 3'd5
    } phase_t;

    typedef struct packed {
        logic                  payload_valid;
        logic [BYTE_W-1:0]     payload_byte;
        logic [WORD_W-1:0]     payload_index;
        logic                  frame_done;
        logic                  frame_fault;
        logic [WORD_W-1:0]     frame_id;
        logic [WORD_W-1:0]     frame_length;
        logic [WORD_W-1:0]     frame_crc;
        logic [SLOT_OUT_W-1:0] frame_slot;
        logic [PHASE_W-1:0]    decoder_phase;
    } result_t;

endpackage

// ===== rtl/core/lpfd_in_if.sv =====
// Input byte channel of the deframer: valid, ready and the received byte.
interface lpfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lpfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/lpfd_out_if.sv =====
// Result channel of the deframer: valid, ready and the decoded fields of one byte.
interface lpfd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            payload_valid;
    logic [lpfd_pkg::BYTE_W-1:0]     payload_byte;
    logic [lpfd_pkg::WORD_W-1:0]     payload_index;
    logic                            frame_done;
    logic                            frame_fault;
    logic [lpfd_pkg::WORD_W-1:0]     frame_id;
    logic [lpfd_pkg::WORD_W-1:0]     frame_length;
    logic [lpfd_pkg::WORD_W-1:0]     frame_crc;
    logic [lpfd_pkg::SLOT_OUT_W-1:0] frame_slot;
    logic [lpfd_pkg::PHASE_W-1:0]    decoder_phase;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output frame_fault, output frame_id, output frame_length,
        output frame_crc, output frame_slot, output decoder_phase,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_done, input frame_fault, input frame_id, input frame_length,
        input frame_crc, input frame_slot, input decoder_phase,
        output ready
    );
endinterface

// ===== rtl/core/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer: input register, decoder and result register.
//
//   Channel   Direction  Transfer condition         Content
//   in_ch     sink       valid && ready             rx_byte
//   out_ch    source     valid && ready             one result per byte
//   cfg       write      cfg_we                     cfg_index, cfg_data
//
// Each byte is held in the input register and is then decoded into the
// result register, from which its result is offered on out_ch.
// One byte is accepted in every cycle while the result side keeps taking results.
// A stalled result holds the result register; the input register and in_ch.ready
// follow it, so nothing is lost. Reset clears the decoder state, the slot counter
// and both valid flags, and restores the start and end byte values.
module length_prefixed_frame_deframer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    lpfd_in_if.sink                                in_ch,
    lpfd_out_if.source                             out_ch,
    input  logic                                   cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lpfd_pkg::BYTE_W-1:0]            cfg_data
);

    logic [lpfd_pkg::BYTE_W-1:0] start_byte_reg;
    logic [lpfd_pkg::BYTE_W-1:0] end_byte_reg;

    logic                        in_valid_reg;
    logic [lpfd_pkg::BYTE_W-1:0] in_byte_reg;

    lpfd_pkg::phase_t            phase_reg, phase_next;
    logic                        field_cnt_reg, field_cnt_next;
    logic [lpfd_pkg::WORD_W-1:0] payload_cnt_reg, payload_cnt_next;
    logic [lpfd_pkg::WORD_W-1:0] id_reg, id_next;
    logic [lpfd_pkg::WORD_W-1:0] length_reg, length_next;
    logic [lpfd_pkg::WORD_W-1:0] crc_reg, crc_next;
    logic [lpfd_pkg::SLOT_W-1:0] slot_reg, slot_next;

    logic                        out_valid_reg;
    lpfd_pkg::result_t           result_reg, result_next;

    logic                        out_load;
    logic                        in_load;
    logic                        step;
    logic [lpfd_pkg::WORD_W-1:0] payload_cnt_inc;
    logic [lpfd_pkg::SLOT_OUT_W-1:0] slot_wide;

    assign out_load    = !out_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && out_load;
    assign in_load     = !in_valid_reg || out_load;
    assign in_ch.ready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= lpfd_pkg::START_BYTE_RESET;
            end_byte_reg   <= lpfd_pkg::END_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lpfd_pkg::cfg_index_t'(cfg_index))
                lpfd_pkg::CFG_START_BYTE: start_byte_reg <= cfg_data;
                lpfd_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_ch.valid)
        begin
            in_byte_reg <= in_ch.rx_byte;
        end
    end

    assign payload_cnt_inc = payload_cnt_reg + 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        field_cnt_next   = field_cnt_reg;
        payload_cnt_next = payload_cnt_reg;
        id_next          = id_reg;
        length_next      = length_reg;
        crc_next         = crc_reg;
        slot_next        = slot_reg;
        result_next      = '0;

        unique case (phase_reg)
            lpfd_pkg::PH_SYNC:
            begin
                if (in_byte_reg == start_byte_reg)
                begin
                    phase_next     = lpfd_pkg::PH_ID;
                    field_cnt_next = 1'b0;
                end
            end
            lpfd_pkg::PH_ID:
            begin
                if (!field_cnt_reg)
                begin
                    if (in_byte_reg != start_byte_reg)
                    begin
                        id_next        = {in_byte_reg, id_reg[7:0]};
                        field_cnt_next = 1'b1;
                    end
                end
                else
                begin
                    id_next        = {id_reg[15:8], in_byte_reg};
                    field_cnt_next = 1'b0;
                    phase_next     = lpfd_pkg::PH_LENGTH;
                end
            end
            lpfd_pkg::PH_LENGTH:
            begin
                if (!field_cnt_reg)
                begin
                    length_next    = {in_byte_reg, length_reg[7:0]};
                    field_cnt_next = 1'b1;
                end
                else
                begin
                    length_next      = {length_reg[15:8], in_byte_reg};
                    field_cnt_next   = 1'b0;
                    payload_cnt_next = '0;
                    phase_next       = ({length_reg[15:8], in_byte_reg} == '0) ?
                                       lpfd_pkg::PH_CRC : lpfd_pkg::PH_PAYLOAD;
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                result_next.payload_valid = 1'b1;
                result_next.payload_byte  = in_byte_reg;
                result_next.payload_index = payload_cnt_reg;
                payload_cnt_next          = payload_cnt_inc;
                if (payload_cnt_inc == length_reg)
                begin
                    field_cnt_next = 1'b0;
                    phase_next     = lpfd_pkg::PH_CRC;
                end
            end
            lpfd_pkg::PH_CRC:
            begin
                if (!field_cnt_reg)
                begin
                    crc_next       = {in_byte_reg, crc_reg[7:0]};
                    field_cnt_next = 1'b1;
                end
                else
                begin
                    crc_next       = {crc_reg[15:8], in_byte_reg};
                    field_cnt_next = 1'b0;
                    phase_next     = lpfd_pkg::PH_END;
                end
            end
            lpfd_pkg::PH_END:
            begin
                if (in_byte_reg == end_byte_reg)
                begin
                    result_next.frame_done = 1'b1;
                    slot_next = (slot_reg == lpfd_pkg::SLOT_LAST) ? '0 :
                                slot_reg + lpfd_pkg::SLOT_W'(1);
                end
                else
                begin
                    result_next.frame_fault = 1'b1;
                end
                field_cnt_next = 1'b0;
                phase_next     = lpfd_pkg::PH_SYNC;
            end
            default:
            begin
                result_next.frame_fault = 1'b1;
                field_cnt_next          = 1'b0;
                phase_next              = lpfd_pkg::PH_SYNC;
            end
        endcase

        result_next.frame_id      = id_next;
        result_next.frame_length  = length_next;
        result_next.frame_crc     = crc_next;
        result_next.frame_slot    = slot_wide;
        result_next.decoder_phase = phase_next;
    end

    assign slot_wide = lpfd_pkg::SLOT_OUT_W'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lpfd_pkg::PH_SYNC;
            field_cnt_reg   <= 1'b0;
            payload_cnt_reg <= '0;
            id_reg          <= '0;
            length_reg      <= '0;
            crc_reg         <= '0;
            slot_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            field_cnt_reg   <= field_cnt_next;
            payload_cnt_reg <= payload_cnt_next;
            id_reg          <= id_next;
            length_reg      <= length_next;
            crc_reg         <= crc_next;
            slot_reg        <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.payload_valid = result_reg.payload_valid;
    assign out_ch.payload_byte  = result_reg.payload_byte;
    assign out_ch.payload_index = result_reg.payload_index;
    assign out_ch.frame_done    = result_reg.frame_done;
    assign out_ch.frame_fault   = result_reg.frame_fault;
    assign out_ch.frame_id      = result_reg.frame_id;
    assign out_ch.frame_length  = result_reg.frame_length;
    assign out_ch.frame_crc     = result_reg.frame_crc;
    assign out_ch.frame_slot    = result_reg.frame_slot;
    assign out_ch.decoder_phase = result_reg.decoder_phase;

endmodule

// ===== dv/length_prefixed_frame_deframer_test.sv =====
// Self-checking testbench of the length-prefixed frame deframer: directed table, then random frames.
module length_prefixed_frame_deframer_test;

    localparam int DIRECTED_ROWS = 21;
    localparam int CONFIG_PHASES = 5;
    localparam int PHASE_BYTES   = 190;
    localparam int STALL_LIMIT   = 1000;

    typedef struct {
        logic [lpfd_pkg::BYTE_W-1:0] rx;
        bit                          typed;
        lpfd_pkg::result_t           res;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    lpfd_pkg::cfg_index_t        cfg_index;
    logic [lpfd_pkg::BYTE_W-1:0] cfg_data;
    logic                        take_ready = 1'b0;
    bit                          steady = 1'b0;

    lpfd_in_if  in_ch ();
    lpfd_out_if out_ch ();

    assign out_ch.ready = take_ready;

    // Copy of the decoder state kept alongside the block.
    lpfd_pkg::phase_t            dec_phase;
    bit                          hi_taken;
    logic [lpfd_pkg::WORD_W-1:0] pay_cnt;
    logic [lpfd_pkg::WORD_W-1:0] id_q;
    logic [lpfd_pkg::WORD_W-1:0] len_q;
    logic [lpfd_pkg::WORD_W-1:0] crc_q;
    logic [lpfd_pkg::SLOT_W-1:0] slot_q;
    logic [lpfd_pkg::BYTE_W-1:0] sof_q;
    logic [lpfd_pkg::BYTE_W-1:0] eof_q;

    lpfd_pkg::result_t pending_results[$];
    int                mismatches = 0;
    int                sent_bytes = 0;
    stim_row_t         directed_rows [DIRECTED_ROWS];

    length_prefixed_frame_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit stall_now();
        return !steady && ($urandom_range(99) < 9);
    endfunction

    function automatic lpfd_pkg::result_t frame_status(
        input bit done, input bit err,
        input logic [lpfd_pkg::WORD_W-1:0] id,
        input logic [lpfd_pkg::WORD_W-1:0] len,
        input logic [lpfd_pkg::WORD_W-1:0] crc,
        input logic [lpfd_pkg::SLOT_OUT_W-1:0] slot,
        input lpfd_pkg::phase_t ph);
        lpfd_pkg::result_t r;
        r = '0;
        r.frame_done    = done;
        r.frame_fault   = err;
        r.frame_id      = id;
        r.frame_length  = len;
        r.frame_crc     = crc;
        r.frame_slot    = slot;
        r.decoder_phase = ph;
        return r;
    endfunction

    function automatic lpfd_pkg::result_t deframe(input logic [lpfd_pkg::BYTE_W-1:0] b);
        lpfd_pkg::result_t r;
        r = '0;
        case (dec_phase)
            lpfd_pkg::PH_SYNC:
            begin
                if (b == sof_q)
                begin
                    dec_phase = lpfd_pkg::PH_ID;
                    hi_taken  = 1'b0;
                end
            end
            lpfd_pkg::PH_ID:
            begin
                if (!hi_taken)
                begin
                    // A start byte in place of the ID high byte restarts the ID.
                    if (b != sof_q)
                    begin
                        id_q[15:8] = b;
                        hi_taken   = 1'b1;
                    end
                end
                else
                begin
                    id_q[7:0] = b;
                    hi_taken  = 1'b0;
                    dec_phase = lpfd_pkg::PH_LENGTH;
                end
            end
            lpfd_pkg::PH_LENGTH:
            begin
                if (!hi_taken)
                begin
                    len_q[15:8] = b;
                    hi_taken    = 1'b1;
                end
                else
                begin
                    len_q[7:0] = b;
                    hi_taken   = 1'b0;
                    pay_cnt    = '0;
                    dec_phase  = (len_q == '0) ? lpfd_pkg::PH_CRC : lpfd_pkg::PH_PAYLOAD;
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = pay_cnt;
                pay_cnt         = pay_cnt + 1'b1;
                if (pay_cnt == len_q)
                begin
                    hi_taken  = 1'b0;
                    dec_phase = lpfd_pkg::PH_CRC;
                end
            end
            lpfd_pkg::PH_CRC:
            begin
                if (!hi_taken)
                begin
                    crc_q[15:8] = b;
                    hi_taken    = 1'b1;
                end
                else
                begin
                    crc_q[7:0] = b;
                    hi_taken   = 1'b0;
                    dec_phase  = lpfd_pkg::PH_END;
                end
            end
            lpfd_pkg::PH_END:
            begin
                r.frame_done  = (b == eof_q);
                r.frame_fault = (b != eof_q);
                hi_taken      = 1'b0;
                dec_phase     = lpfd_pkg::PH_SYNC;
            end
            default:
            begin
                r.frame_fault = 1'b1;
                hi_taken      = 1'b0;
                dec_phase     = lpfd_pkg::PH_SYNC;
            end
        endcase
        r.frame_id      = id_q;
        r.frame_length  = len_q;
        r.frame_crc     = crc_q;
        r.frame_slot    = lpfd_pkg::SLOT_OUT_W'(slot_q);
        r.decoder_phase = dec_phase;
        if (r.frame_done)
        begin
            slot_q = (slot_q == lpfd_pkg::SLOT_LAST) ? '0 : slot_q + 1'b1;
        end
        return r;
    endfunction

    task automatic send_byte(input logic [lpfd_pkg::BYTE_W-1:0] b, input bit typed,
                             input lpfd_pkg::result_t typed_res);
        lpfd_pkg::result_t predicted;
        while (stall_now())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        sent_bytes++;
        predicted = deframe(b);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_frame(input int forced_len);
        logic [lpfd_pkg::BYTE_W-1:0] frame_q[$];
        logic [lpfd_pkg::WORD_W-1:0] id;
        int                          kind;
        int                          len;
        int                          cut;
        kind = (forced_len >= 0) ? 99 : $urandom_range(99);
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 6))
                frame_q.push_back(lpfd_pkg::BYTE_W'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                frame_q.push_back(lpfd_pkg::BYTE_W'($urandom_range(255)));
            frame_q.push_back(sof_q);
            if ($urandom_range(9) == 0)
            begin
                frame_q.push_back(sof_q);
            end
            id = lpfd_pkg::WORD_W'($urandom);
            frame_q.push_back(id[15:8]);
            frame_q.push_back(id[7:0]);
            if (forced_len >= 0)
            begin
                len = forced_len;
            end
            else
            begin
                cut = $urandom_range(99);
                len = (cut < 5) ? 0 : (cut < 96) ? $urandom_range(1, 12) :
                      $urandom_range(256, 300);
            end
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
            repeat (len) frame_q.push_back(lpfd_pkg::BYTE_W'($urandom_range(255)));
            frame_q.push_back(lpfd_pkg::BYTE_W'($urandom_range(255)));
            frame_q.push_back(lpfd_pkg::BYTE_W'($urandom_range(255)));
            frame_q.push_back(($urandom_range(9) == 0) ?
                              lpfd_pkg::BYTE_W'($urandom_range(255)) : eof_q);
            if (kind < 15)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
        end
        foreach (frame_q[i])
        begin
            send_byte(frame_q[i], 1'b0, '0);
        end
    endtask

    task automatic write_config(input logic [lpfd_pkg::BYTE_W-1:0] sof,
                                input logic [lpfd_pkg::BYTE_W-1:0] eof);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lpfd_pkg::CFG_START_BYTE;
        cfg_data  <= sof;
        @(posedge clk);
        sof_q      = sof;
        cfg_index <= lpfd_pkg::CFG_END_BYTE;
        cfg_data  <= eof;
        @(posedge clk);
        eof_q   = eof;
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [lpfd_pkg::WORD_W-1:0] want,
                               input logic [lpfd_pkg::WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : take_result
        lpfd_pkg::result_t want;
        lpfd_pkg::result_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.payload_valid = out_ch.payload_valid;
            got.payload_byte  = out_ch.payload_byte;
            got.payload_index = out_ch.payload_index;
            got.frame_done    = out_ch.frame_done;
            got.frame_fault   = out_ch.frame_fault;
            got.frame_id      = out_ch.frame_id;
            got.frame_length  = out_ch.frame_length;
            got.frame_crc     = out_ch.frame_crc;
            got.frame_slot    = out_ch.frame_slot;
            got.decoder_phase = out_ch.decoder_phase;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none, got %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("payload_valid", lpfd_pkg::WORD_W'(want.payload_valid),
                            lpfd_pkg::WORD_W'(got.payload_valid));
                check_field("payload_byte", lpfd_pkg::WORD_W'(want.payload_byte),
                            lpfd_pkg::WORD_W'(got.payload_byte));
                check_field("payload_index", want.payload_index, got.payload_index);
                check_field("frame_done", lpfd_pkg::WORD_W'(want.frame_done),
                            lpfd_pkg::WORD_W'(got.frame_done));
                check_field("frame_fault", lpfd_pkg::WORD_W'(want.frame_fault),
                            lpfd_pkg::WORD_W'(got.frame_fault));
                check_field("frame_id", want.frame_id, got.frame_id);
                check_field("frame_length", want.frame_length, got.frame_length);
                check_field("frame_crc", want.frame_crc, got.frame_crc);
                check_field("frame_slot", lpfd_pkg::WORD_W'(want.frame_slot),
                            lpfd_pkg::WORD_W'(got.frame_slot));
                check_field("decoder_phase", lpfd_pkg::WORD_W'(want.decoder_phase),
                            lpfd_pkg::WORD_W'(got.decoder_phase));
            end
        end
        take_ready <= !stall_now();
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [lpfd_pkg::BYTE_W-1:0] sof_list [CONFIG_PHASES];
        logic [lpfd_pkg::BYTE_W-1:0] eof_list [CONFIG_PHASES];
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_index     = lpfd_pkg::CFG_START_BYTE;
        cfg_data      = '0;
        dec_phase     = lpfd_pkg::PH_SYNC;
        hi_taken      = 1'b0;
        pay_cnt       = '0;
        id_q          = '0;
        len_q         = '0;
        crc_q         = '0;
        slot_q        = '0;
        sof_q         = lpfd_pkg::START_BYTE_RESET;
        eof_q         = lpfd_pkg::END_BYTE_RESET;

        // The rows assume the start and end bytes left by reset.
        directed_rows = '{
            '{8'h00, 1'b1, frame_status(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 2'd0,
                                        lpfd_pkg::PH_SYNC)},
            '{8'hFF, 1'b1, frame_status(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 2'd0,
                                        lpfd_pkg::PH_SYNC)},
            '{8'h55, 1'b1, frame_status(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 2'd0,
                                        lpfd_pkg::PH_ID)},
            '{8'h55, 1'b1, frame_status(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 2'd0,
                                        lpfd_pkg::PH_ID)},
            '{8'hFF, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, frame_status(1'b0, 1'b0, 16'hFFA5, 16'h0000, 16'h0000, 2'd0,
                                        lpfd_pkg::PH_CRC)},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h0D, 1'b1, frame_status(1'b1, 1'b0, 16'hFFA5, 16'h0000, 16'h00FF, 2'd0,
                                        lpfd_pkg::PH_SYNC)},
            '{8'h55, 1'b0, '0},
            '{8'h12, 1'b0, '0},
            '{8'h34, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h0C, 1'b1, frame_status(1'b0, 1'b1, 16'h1234, 16'h0002, 16'hFF00, 2'd1,
                                        lpfd_pkg::PH_SYNC)}
        };

        sof_list = '{lpfd_pkg::START_BYTE_RESET, 8'h00, 8'hFF,
                     lpfd_pkg::BYTE_W'($urandom_range(255)),
                     lpfd_pkg::BYTE_W'($urandom_range(255))};
        eof_list = '{lpfd_pkg::END_BYTE_RESET, 8'hFF, 8'h00,
                     lpfd_pkg::BYTE_W'($urandom_range(255)),
                     lpfd_pkg::BYTE_W'($urandom_range(255))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < CONFIG_PHASES; p++)
        begin
            if (p > 0)
            begin
                write_config(sof_list[p], eof_list[p]);
            end
            steady = (p == 2);
            while (sent_bytes < PHASE_BYTES * (p + 1))
            begin
                send_frame(-1);
            end
        end
        steady = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_in_if.sv
rtl/core/lpfd_out_if.sv
rtl/core/length_prefixed_frame_deframer.sv
dv/length_prefixed_frame_deframer_test.sv
